/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/kpsd_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad scan and debounce package
// Field widths, register indexes and reset values of the keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int LINE_W      = 4;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 8;
    localparam int CFG_INDEX_W = 2;

    typedef logic [LINE_W-1:0]      line_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_IDX_PRESS_COUNT   = 2'd0;
    localparam cfg_index_t CFG_IDX_RELEASE_COUNT = 2'd1;

    localparam cnt_t PRESS_COUNT_RESET   = 8'd33;
    localparam cnt_t RELEASE_COUNT_RESET = 8'd32;

endpackage

/* rtl/keypad_scan_debounce_top.sv */
// The result word is registered at the edge that accepts its input word.
// Throughput: one word per clock while the consumer takes every result word; a result
// word that waits holds off the input until it leaves, since there is one result register.
// Reset: all control state clears at once; press_count and release_count return
// to 33 and 32 and the counters reload to those values.
// ----------------------------------------------------------------------------
// Keypad scan and debounce top level
// Scans a 4x4 key matrix one position per word, debounces presses, detects
// release and drives a beeper while a key is held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_scan_debounce_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  kpsd_pkg::line_t         return_lines,
    input  logic                    key_ack,
    output logic                    out_valid,
    input  logic                    out_ready,
    output kpsd_pkg::line_t         scan_drive,
    output logic                    key_valid,
    output kpsd_pkg::pos_t          key_index,
    output logic                    key_released,
    output logic                    beeper,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  kpsd_pkg::cfg_index_t    cfg_index,
    input  kpsd_pkg::cnt_t          cfg_data
);
    import kpsd_pkg::*;

    // Configuration registers.
    cnt_t  press_count_reg;
    cnt_t  release_count_reg;

    // Scanner state.
    pos_t  scan_pos_reg,        scan_pos_next;
    cnt_t  press_counter_reg,   press_counter_next;
    cnt_t  release_counter_reg, release_counter_next;
    logic  key_latched_reg,     key_latched_next;
    pos_t  captured_index_reg,  captured_index_next;
    logic  release_seen_reg,    release_seen_next;
    logic  beeper_active_reg,   beeper_active_next;
    logic  beeper_level_reg,    beeper_level_next;

    // Result register.
    logic  out_valid_reg,       out_valid_next;
    line_t scan_drive_reg,      scan_drive_next;

    logic  in_fire;
    logic  ack_clear;
    logic  latched_after_ack;
    logic  seen_after_ack;
    logic  pressed;
    cnt_t  press_dec;
    cnt_t  release_dec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign scan_drive   = scan_drive_reg;
    assign key_valid    = key_latched_reg;
    assign key_index    = captured_index_reg;
    assign key_released = release_seen_reg;
    assign beeper       = beeper_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_count_reg   <= PRESS_COUNT_RESET;
            release_count_reg <= RELEASE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_PRESS_COUNT:   press_count_reg   <= cfg_data;
                CFG_IDX_RELEASE_COUNT: release_count_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        // An acknowledge only counts once release has been seen, and it takes
        // effect before this word's sample.
        ack_clear         = key_ack && release_seen_reg;
        latched_after_ack = key_latched_reg && !ack_clear;
        seen_after_ack    = release_seen_reg && !ack_clear;

        pressed     = !return_lines[scan_pos_reg[1:0]];
        press_dec   = press_counter_reg - 8'd1;
        release_dec = release_counter_reg - 8'd1;

        press_counter_next   = press_counter_reg;
        release_counter_next = release_counter_reg;
        key_latched_next     = latched_after_ack;
        captured_index_next  = captured_index_reg;
        release_seen_next    = seen_after_ack;
        beeper_active_next   = beeper_active_reg;
        beeper_level_next    = beeper_level_reg ^ beeper_active_reg;
        scan_pos_next        = scan_pos_reg + 4'd1;
        scan_drive_next      = ~(4'b0001 << scan_pos_reg[3:2]);

        if (!latched_after_ack)
        begin
            // A counter equal to press_count means no window is running.
            if (press_counter_reg == press_count_reg)
            begin
                if (pressed)
                begin
                    press_counter_next  = press_dec;
                    captured_index_next = scan_pos_reg;
                end
            end
            else if (press_dec == '0)
            begin
                press_counter_next = press_count_reg;
                if (pressed)
                begin
                    key_latched_next   = 1'b1;
                    beeper_active_next = 1'b1;
                end
            end
            else
            begin
                press_counter_next = press_dec;
            end
        end
        else
        begin
            if (pressed)
            begin
                release_counter_next = release_count_reg;
            end
            else if (release_dec == '0)
            begin
                release_seen_next    = 1'b1;
                beeper_active_next   = 1'b0;
                release_counter_next = release_count_reg;
            end
            else
            begin
                release_counter_next = release_dec;
            end
        end

        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg        <= '0;
            press_counter_reg   <= PRESS_COUNT_RESET;
            release_counter_reg <= RELEASE_COUNT_RESET;
            key_latched_reg     <= 1'b0;
            captured_index_reg  <= '0;
            release_seen_reg    <= 1'b0;
            beeper_active_reg   <= 1'b0;
            beeper_level_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                scan_pos_reg        <= scan_pos_next;
                press_counter_reg   <= press_counter_next;
                release_counter_reg <= release_counter_next;
                key_latched_reg     <= key_latched_next;
                captured_index_reg  <= captured_index_next;
                release_seen_reg    <= release_seen_next;
                beeper_active_reg   <= beeper_active_next;
                beeper_level_reg    <= beeper_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scan_drive_reg <= scan_drive_next;
        end
    end

    // Release can only be flagged for a key that is still latched.
    `ASSERT_SAME(a_release_needs_key, release_seen_reg, key_latched_reg)
    // The beeper runs only while a key is latched.
    `ASSERT_SAME(a_beeper_needs_key, beeper_active_reg, key_latched_reg)
    // Each accepted word moves the scan to the next position.
    `ASSERT_NEXT(a_scan_advance, in_fire, scan_pos_reg == $past(scan_pos_reg) + 4'd1)

endmodule

/* sim/keypad_scan_debounce_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad scanner result checker
// Watches the scan, result and register channels of the keypad scanner. It
// keeps its own copy of the scan and debounce state, works out the result
// word for every accepted scan word and compares each result word with it.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_checker
    import kpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  line_t      return_lines,
    input  logic       key_ack,
    input  logic       out_valid,
    input  logic       out_ready,
    input  line_t      scan_drive,
    input  logic       key_valid,
    input  pos_t       key_index,
    input  logic       key_released,
    input  logic       beeper,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  cnt_t       cfg_data,
    output int         mismatches,
    output int         words_pending
);

    typedef struct {
        line_t drive;
        logic  valid;
        pos_t  index;
        logic  released;
        logic  beep;
    } scan_result_t;

    scan_result_t expected_words[$];

    // Register copies.
    cnt_t press_len;
    cnt_t release_len;

    // Scanner state.
    pos_t scan_pos;
    cnt_t press_cnt;
    cnt_t release_cnt;
    logic latched;
    pos_t cand_index;
    logic released;
    logic beep_on;
    logic beep_lvl;

    initial
    begin
        mismatches    = 0;
        words_pending = 0;
    end

    task automatic scan_tick(input line_t lines, input logic ack, output scan_result_t res);
        logic [1:0] row;
        logic [1:0] col;
        logic       pressed;
        row     = scan_pos[3:2];
        col     = scan_pos[1:0];
        pressed = !lines[col];
        res.drive = ~(line_t'(1) << row);

        // An acknowledge only counts once release has been seen.
        if (ack && released)
        begin
            latched  = 1'b0;
            released = 1'b0;
        end

        if (beep_on)
            beep_lvl = !beep_lvl;

        if (!latched)
        begin
            if (press_cnt == press_len)
            begin
                if (pressed)
                begin
                    press_cnt  = press_cnt - 1'b1;
                    cand_index = scan_pos;
                end
            end
            else
            begin
                press_cnt = press_cnt - 1'b1;
                if (press_cnt == '0)
                begin
                    press_cnt = press_len;
                    if (pressed)
                    begin
                        latched = 1'b1;
                        beep_on = 1'b1;
                    end
                end
            end
        end
        else if (pressed)
        begin
            release_cnt = release_len;
        end
        else
        begin
            release_cnt = release_cnt - 1'b1;
            if (release_cnt == '0)
            begin
                released    = 1'b1;
                beep_on     = 1'b0;
                release_cnt = release_len;
            end
        end

        scan_pos = scan_pos + 1'b1;

        res.valid    = latched;
        res.index    = cand_index;
        res.released = released;
        res.beep     = beep_lvl;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        scan_result_t want;
        if (!rst_n)
        begin
            press_len   = PRESS_COUNT_RESET;
            release_len = RELEASE_COUNT_RESET;
            scan_pos    = '0;
            press_cnt   = PRESS_COUNT_RESET;
            release_cnt = RELEASE_COUNT_RESET;
            latched     = 1'b0;
            cand_index  = '0;
            released    = 1'b0;
            beep_on     = 1'b0;
            beep_lvl    = 1'b0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDX_PRESS_COUNT:   press_len   = cfg_data;
                    CFG_IDX_RELEASE_COUNT: release_len = cfg_data;
                    default: ;
                endcase
            end

            // The result word leaving now belongs to an earlier scan word, so it is
            // checked before the word accepted at this edge is predicted.
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual drive %0h",
                             $time, scan_drive);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("scan_drive", want.drive, scan_drive);
                    check_field("key_valid", want.valid, key_valid);
                    check_field("key_index", want.index, key_index);
                    check_field("key_released", want.released, key_released);
                    check_field("beeper", want.beep, beeper);
                end
            end

            if (in_valid && in_ready)
            begin
                scan_tick(return_lines, key_ack, want);
                expected_words.push_back(want);
            end
        end
        words_pending = expected_words.size();
    end

endmodule

/* sim/keypad_scan_debounce_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Offers scan words to the keypad scanner as key strokes and noise under
// several debounce settings, stalls both channels at random and lets the
// checker compare every result word.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_top_tb;
    import kpsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    line_t      return_lines;
    logic       key_ack;
    logic       out_valid;
    logic       out_ready;
    line_t      scan_drive;
    logic       key_valid;
    pos_t       key_index;
    logic       key_released;
    logic       beeper;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    cnt_t       cfg_data;

    int mismatches;
    int words_pending;
    int sent_count  = 0;
    int cycle_count = 0;
    bit send_calm   = 1'b0;
    bit drain_calm  = 1'b0;
    bit drain_held  = 1'b0;

    keypad_scan_debounce_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .return_lines (return_lines),
        .key_ack      (key_ack),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scan_drive   (scan_drive),
        .key_valid    (key_valid),
        .key_index    (key_index),
        .key_released (key_released),
        .beeper       (beeper),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    keypad_scan_debounce_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .return_lines  (return_lines),
        .key_ack       (key_ack),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scan_drive    (scan_drive),
        .key_valid     (key_valid),
        .key_index     (key_index),
        .key_released  (key_released),
        .beeper        (beeper),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keypad_scan_debounce_top test failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_word(input line_t lines, input logic ack);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        return_lines <= lines;
        key_ack      <= ack;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_count++;
        if ($urandom_range(0, 49) == 0)
            send_calm = !send_calm;
    endtask

    task automatic write_reg(input cfg_index_t idx, input cnt_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until every result word is back and the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (words_pending != 0);
        repeat (3) @(negedge clk);
    endtask

    // Key strokes: a press held for a while, then quiet lines, with acknowledges
    // sprinkled in, and some words of plain noise between strokes.
    task automatic run_strokes(input int words, input int max_hold, input int max_quiet);
        int    done_words;
        int    hold;
        int    quiet;
        int    i;
        line_t pattern;
        done_words = 0;
        while (done_words < words)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send_word(line_t'($urandom), 1'($urandom_range(0, 1)));
                done_words++;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       pattern = '0;
                    1:       pattern = ~(line_t'(1) << $urandom_range(0, 3));
                    default: pattern = line_t'($urandom);
                endcase
                hold = $urandom_range(1, max_hold);
                for (i = 0; i < hold && done_words < words; i++)
                begin
                    send_word(pattern, $urandom_range(0, 7) == 0);
                    done_words++;
                end
                quiet = $urandom_range(0, max_quiet);
                for (i = 0; i < quiet && done_words < words; i++)
                begin
                    send_word('1, $urandom_range(0, 3) == 0);
                    done_words++;
                end
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off while words keep coming
    // so that the block backs up and stops taking scan words.
    initial
    begin : drain
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!drain_held && sent_count >= 600)
            begin
                n = 80;
                drain_held = 1'b1;
            end
            else
            begin
                n = pick_gap(drain_calm);
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            if ($urandom_range(0, 59) == 0)
                drain_calm = !drain_calm;
        end
    end

    initial
    begin : stimulus
        int   i;
        cnt_t p_len;
        cnt_t r_len;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        return_lines = '1;
        key_ack      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_IDX_PRESS_COUNT;
        cfg_data     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every return line pattern once, with the acknowledge taken from bit 0 of the pattern, at reset settings.
        for (i = 0; i < 16; i++)
            send_word(line_t'(i), i[0]);
        send_word('0, 1'b1);
        send_word('1, 1'b1);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        settle();

        // Shortest windows.
        write_reg(CFG_IDX_PRESS_COUNT, 8'd2);
        write_reg(CFG_IDX_RELEASE_COUNT, 8'd1);
        run_strokes(200, 8, 7);
        settle();

        // Writes to unused indexes must change nothing; then the longest windows.
        write_reg(cfg_index_t'(2), cnt_t'($urandom));
        write_reg(cfg_index_t'(3), cnt_t'($urandom));
        write_reg(CFG_IDX_PRESS_COUNT, 8'd255);
        write_reg(CFG_IDX_RELEASE_COUNT, 8'd255);
        run_strokes(120, 40, 40);
        settle();

        p_len = cnt_t'($urandom_range(2, 12));
        r_len = cnt_t'($urandom_range(1, 12));
        write_reg(CFG_IDX_PRESS_COUNT, p_len);
        write_reg(CFG_IDX_RELEASE_COUNT, r_len);
        run_strokes(200, p_len + 6, r_len + 6);
        settle();

        p_len = cnt_t'($urandom_range(2, 24));
        r_len = cnt_t'($urandom_range(1, 24));
        write_reg(CFG_IDX_PRESS_COUNT, p_len);
        write_reg(CFG_IDX_RELEASE_COUNT, r_len);
        run_strokes(200, p_len + 6, r_len + 6);
        settle();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("keypad_scan_debounce_top test passed");
        else
            $display("keypad_scan_debounce_top test failed");
        $finish;
    end

endmodule
